[rtl/arpc_pkg.sv]
// shared types and constants for the arp responder with address cache
package arpc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;
  localparam int OPC_W = 16;

  localparam int CACHE_ENTRIES_DEF = 16;

  // configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 64;
  localparam logic REG_OWN_IP  = 1'b0;
  localparam logic REG_OWN_MAC = 1'b1;

  localparam logic CMD_PACKET  = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  localparam logic [OPC_W-1:0] OPC_REQUEST = 16'd1;
  localparam logic [OPC_W-1:0] OPC_REPLY   = 16'd2;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_HIT   = 2'd2,
    ACT_BCAST = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } st_t;

  typedef struct packed {
    logic             cmd;
    logic [OPC_W-1:0] arp_opcode;
    logic [MAC_W-1:0] src_mac;
    logic [IP_W-1:0]  src_ip;
    logic [IP_W-1:0]  tgt_ip;
  } item_t;

  typedef struct packed {
    act_t             action;
    logic [MAC_W-1:0] peer_mac;
    logic [IP_W-1:0]  peer_ip;
  } res_t;

  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/arpc_in_if.sv]
// input channel: received arp packet or resolve request
interface arpc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [arpc_pkg::OPC_W-1:0] arp_opcode;
  logic [arpc_pkg::MAC_W-1:0] src_mac;
  logic [arpc_pkg::IP_W-1:0]  src_ip;
  logic [arpc_pkg::IP_W-1:0]  tgt_ip;

  modport source (output valid, cmd, arp_opcode, src_mac, src_ip, tgt_ip,
                  input ready);
  modport sink (input valid, cmd, arp_opcode, src_mac, src_ip, tgt_ip,
                output ready);
endinterface

[rtl/arpc_out_if.sv]
// result channel: action with peer addresses
interface arpc_out_if;
  logic                       valid;
  logic                       ready;
  arpc_pkg::act_t             action;
  logic [arpc_pkg::MAC_W-1:0] peer_mac;
  logic [arpc_pkg::IP_W-1:0]  peer_ip;

  modport source (output valid, action, peer_mac, peer_ip, input ready);
  modport sink (input valid, action, peer_mac, peer_ip, output ready);
endinterface

[rtl/arp_responder_with_cache.sv]
// arp responder with address cache: top level with output register
// a packet that stores nothing goes to its result without a cache scan;
// a resolve or a stored reply scans the cache one slot per cycle through the ram read
// port; every result leaves through the output register
// one item at a time: a new item is taken only once the last result has left the sequencer
// reset: synchronous active low; valid bits, pending flag, state, output valid and config registers clear, no ram pass
module arp_responder_with_cache #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  arpc_in_if.sink                     in_ch,
  arpc_out_if.source                  out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [arpc_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [arpc_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [arpc_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import arpc_pkg::*;

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  logic [IP_W-1:0]  own_ip;
  item_t            in_item;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  // output register: a finished result waits here while the next beat comes in
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r, out_res_nxt;

  assign in_item = '{cmd: in_ch.cmd, arp_opcode: in_ch.arp_opcode,
                     src_mac: in_ch.src_mac, src_ip: in_ch.src_ip,
                     tgt_ip: in_ch.tgt_ip};

  // own_ip / own_mac registers on the apb port
  arpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .own_ip  (own_ip)
  );

  // cache entries: ip and mac side by side in one ram
  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // scan sequencer; first match in slot order wins, the fill write ends the scan
  arpc_ctrl #(
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .own_ip    (own_ip),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // the register takes a new result when empty or when its beat leaves this cycle
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.action   = out_res_r.action;
  assign out_ch.peer_mac = out_res_r.peer_mac;
  assign out_ch.peer_ip  = out_res_r.peer_ip;

endmodule

[rtl/arpc_ram.sv]
// generic single-write, single-read ram with registered read data
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/arpc_cfg.sv]
// apb register block: own ip and own mac
module arpc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [arpc_pkg::APB_AW-1:0]   paddr,
  input  logic [arpc_pkg::APB_DW-1:0]   pwdata,
  output logic [arpc_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [arpc_pkg::IP_W-1:0]     own_ip
);
  import arpc_pkg::*;

  logic [IP_W-1:0]  own_ip_r;
  logic [MAC_W-1:0] own_mac_r;
  logic             wr_en;
  logic             reg_sel;

  // registers sit on an 8-byte stride
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
    end else if (wr_en) begin
      if (reg_sel == REG_OWN_MAC) begin
        own_mac_r <= pwdata[MAC_W-1:0];
      end else begin
        own_ip_r <= pwdata[IP_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == REG_OWN_MAC) begin
      prdata = {{(APB_DW-MAC_W){1'b0}}, own_mac_r};
    end else begin
      prdata = {{(APB_DW-IP_W){1'b0}}, own_ip_r};
    end
  end

  assign own_ip = own_ip_r;

endmodule

[rtl/arpc_ctrl.sv]
// sequencer: cache scan, fill, pending flag and result build
module arpc_ctrl #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  arpc_pkg::item_t             in_item,
  input  logic [arpc_pkg::IP_W-1:0]   own_ip,
  output logic                        ram_we,
  output logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] ram_waddr,
  output arpc_pkg::entry_t            ram_wdata,
  output logic [((CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1)-1:0] ram_raddr,
  input  arpc_pkg::entry_t            ram_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output arpc_pkg::res_t              res
);
  import arpc_pkg::*;

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CACHE_ENTRIES);

  st_t                      state_r, state_nxt;
  item_t                    item_r, item_nxt;
  res_t                     res_r, res_nxt;
  logic [CNT_W-1:0]         issue_r, issue_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]         chk_idx_r, chk_idx_nxt;
  logic                     vld_q_r, vld_q_nxt;
  logic [CACHE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                     pending_r, pending_nxt;
  logic [IP_W-1:0]          e_ip;
  logic [MAC_W-1:0]         e_mac;

  // entries never written read as empty
  assign e_ip  = vld_q_r ? ram_rdata.ip  : '0;
  assign e_mac = vld_q_r ? ram_rdata.mac : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      chk_vld_r <= 1'b0;
      valid_r   <= '0;
      pending_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= chk_vld_nxt;
      valid_r   <= valid_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    res_r     <= res_nxt;
    issue_r   <= issue_nxt;
    chk_idx_r <= chk_idx_nxt;
    vld_q_r   <= vld_q_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    res_nxt     = res_r;
    issue_nxt   = issue_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    vld_q_nxt   = vld_q_r;
    valid_nxt   = valid_r;
    pending_nxt = pending_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = chk_idx_r;
    ram_wdata   = '{ip: item_r.src_ip, mac: item_r.src_mac};
    ram_raddr   = issue_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt    = in_item;
          issue_nxt   = '0;
          chk_vld_nxt = 1'b0;
          if (in_item.cmd == CMD_PACKET &&
              !(pending_r && in_item.arp_opcode == OPC_REPLY)) begin
            if (in_item.arp_opcode == OPC_REQUEST && in_item.tgt_ip == own_ip) begin
              res_nxt = '{action: ACT_REPLY, peer_mac: in_item.src_mac,
                          peer_ip: in_item.src_ip};
            end else begin
              res_nxt = '{action: ACT_NONE, peer_mac: '0, peer_ip: '0};
            end
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // read issue runs one slot ahead of the compare
        if (issue_r != LAST_CNT) begin
          issue_nxt   = issue_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = issue_r[IDX_W-1:0];
          vld_q_nxt   = valid_r[issue_r[IDX_W-1:0]];
        end else begin
          chk_vld_nxt = 1'b0;
        end

        if (chk_vld_r) begin
          if (item_r.cmd == CMD_PACKET) begin
            if (e_ip == '0) begin
              ram_we                 = 1'b1;
              valid_nxt[chk_idx_r]   = 1'b1;
              pending_nxt            = 1'b0;
              res_nxt = '{action: ACT_NONE, peer_mac: '0, peer_ip: '0};
              chk_vld_nxt            = 1'b0;
              state_nxt              = ST_FINISH;
            end
          end else if (e_ip == item_r.tgt_ip) begin
            res_nxt = '{action: ACT_HIT, peer_mac: e_mac, peer_ip: item_r.tgt_ip};
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_FINISH;
          end
        end else if (issue_r == LAST_CNT) begin
          // all slots checked without a match
          chk_vld_nxt = 1'b0;
          if (item_r.cmd == CMD_PACKET) begin
            pending_nxt = 1'b0;
            res_nxt = '{action: ACT_NONE, peer_mac: '0, peer_ip: '0};
          end else begin
            pending_nxt = 1'b1;
            res_nxt = '{action: ACT_BCAST, peer_mac: '0, peer_ip: item_r.tgt_ip};
          end
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule
